// ----- hw/rtl/cle_pkg.sv -----
// ----------------------------------------------------------------------------
// cle_pkg
// Shared types and codes of the cursor list engine: request and result
// payloads, request type codes and result status codes.
// ----------------------------------------------------------------------------
package cle_pkg;

	localparam logic [2:0] REQ_INSERT = 3'd0;
	localparam logic [2:0] REQ_APPEND = 3'd1;
	localparam logic [2:0] REQ_ERASE  = 3'd2;
	localparam logic [2:0] REQ_NEXT   = 3'd3;
	localparam logic [2:0] REQ_PREV   = 3'd4;
	localparam logic [2:0] REQ_CLEAR  = 3'd5;

	localparam logic [1:0] ST_DONE  = 2'd0;
	localparam logic [1:0] ST_EMPTY = 2'd1;
	localparam logic [1:0] ST_FULL  = 2'd2;

	typedef struct packed {
		logic [2:0]         req_type;
		logic signed [31:0] elem_in;
	} req_t;

	typedef struct packed {
		logic [1:0]         status;
		logic [7:0]         length;
		logic [7:0]         position;
		logic               has_current;
		logic signed [31:0] current_value;
	} rsp_t;

endpackage

// ----- hw/rtl/cle_stream_if.sv -----
// ----------------------------------------------------------------------------
// cle_stream_if
// Valid/ready channel carrying one payload item per handshake.
// ----------------------------------------------------------------------------
interface cle_stream_if #(
	parameter type T = logic
) ();
	logic valid;
	logic ready;
	T     data;

	modport source (output valid, output data, input ready);
	modport sink   (input valid, input data, output ready);
endinterface

// ----- hw/rtl/cle_node_mem.sv -----
// ----------------------------------------------------------------------------
// cle_node_mem
// Node store: successor links and element values, one write port each and
// one shared read address with registered read data.
// ----------------------------------------------------------------------------
module cle_node_mem #(
	parameter int NODES    = 256,
	parameter int VAL_BITS = 32
) (
	input  logic                       clk,
	input  logic [$clog2(NODES)-1:0]   rd_addr,
	output logic [$clog2(NODES)-1:0]   link_rd,
	output logic [VAL_BITS-1:0]        val_rd,
	input  logic                       link_we,
	input  logic [$clog2(NODES)-1:0]   link_wa,
	input  logic [$clog2(NODES)-1:0]   link_wd,
	input  logic                       val_we,
	input  logic [$clog2(NODES)-1:0]   val_wa,
	input  logic [VAL_BITS-1:0]        val_wd
);
	localparam int IW = $clog2(NODES);

	logic [IW-1:0]       links_q [NODES];
	logic [VAL_BITS-1:0] vals_q  [NODES];

	always_ff @(posedge clk) begin
		link_rd <= links_q[rd_addr];
		if (link_we) begin
			links_q[link_wa] <= link_wd;
		end
	end

	always_ff @(posedge clk) begin
		val_rd <= vals_q[rd_addr];
		if (val_we) begin
			vals_q[val_wa] <= val_wd;
		end
	end
endmodule

// ----- hw/rtl/cle_seq.sv -----
// ----------------------------------------------------------------------------
// cle_seq
// Sequencer of the cursor list engine: holds the list registers and steps
// each request through reads and writes of the node store.
// ----------------------------------------------------------------------------
module cle_seq import cle_pkg::*; #(
	parameter int NODES     = 256,
	parameter int ELEM_BITS = 32
) (
	input  logic                                       clk,
	input  logic                                       arst_n,
	input  logic                                       start,
	input  req_t                                       req,
	output logic                                       idle,
	output logic                                       res_valid,
	input  logic                                       res_take,
	output rsp_t                                       res,
	output logic [$clog2(NODES)-1:0]                   rd_addr,
	input  logic [$clog2(NODES)-1:0]                   link_rd,
	input  logic [((ELEM_BITS < 32) ? ELEM_BITS : 32)-1:0] val_rd,
	output logic                                       link_we,
	output logic [$clog2(NODES)-1:0]                   link_wa,
	output logic [$clog2(NODES)-1:0]                   link_wd,
	output logic                                       val_we,
	output logic [$clog2(NODES)-1:0]                   val_wa,
	output logic [((ELEM_BITS < 32) ? ELEM_BITS : 32)-1:0] val_wd
);
	localparam int IW = $clog2(NODES);
	localparam int VW = (ELEM_BITS < 32) ? ELEM_BITS : 32;
	localparam logic [IW:0] FRESH_END = (IW + 1)'(NODES);

	localparam logic [3:0] S_IDLE    = 4'd0;
	localparam logic [3:0] S_LINK1   = 4'd1;
	localparam logic [3:0] S_LINK2   = 4'd2;
	localparam logic [3:0] S_WALK    = 4'd3;
	localparam logic [3:0] S_ERA_LK  = 4'd4;
	localparam logic [3:0] S_ERA_REL = 4'd5;
	localparam logic [3:0] S_NXT_LK  = 4'd6;
	localparam logic [3:0] S_VAL     = 4'd7;
	localparam logic [3:0] S_DONE    = 4'd8;

	logic [3:0]    state_q;
	logic [2:0]    op_q;
	logic [VW-1:0] elem_q;
	logic [1:0]    status_q;
	logic [IW-1:0] sent_q, cur_q, tail_q, free_q, succ_q, node_q, walk_p_q;
	logic [IW-1:0] len_q, pos_q;
	logic [IW:0]   fresh_q;
	logic [VW-1:0] sval_q;
	logic          from_free_q;
	logic          walk_mem_q;

	logic [IW-1:0] anchor;
	logic [IW-1:0] walk_next;
	logic          walk_hit;

	// insert hooks behind the cursor, append behind the tail
	assign anchor    = (op_q == REQ_INSERT) ? cur_q : tail_q;
	assign walk_next = walk_mem_q ? link_rd : sent_q;
	assign walk_hit  = (walk_next == cur_q);

	assign idle      = (state_q == S_IDLE);
	assign res_valid = (state_q == S_DONE);

	always_comb begin
		res.status        = status_q;
		res.length        = 8'(len_q);
		res.position      = 8'(pos_q);
		res.has_current   = (succ_q != '0);
		res.current_value = (succ_q != '0) ? 32'(sval_q) : 32'sd0;
	end

	always_comb begin
		rd_addr = '0;
		link_we = 1'b0;
		link_wa = '0;
		link_wd = '0;
		val_we  = 1'b0;
		val_wa  = '0;
		val_wd  = elem_q;
		case (state_q)
			S_IDLE: begin
				rd_addr = (req.req_type inside {REQ_INSERT, REQ_APPEND}) ? free_q : succ_q;
			end
			S_LINK1: begin
				val_we  = 1'b1;
				val_wa  = node_q;
				link_we = 1'b1;
				link_wa = node_q;
				link_wd = (op_q == REQ_INSERT) ? succ_q : '0;
			end
			S_LINK2: begin
				link_we = (anchor != '0);
				link_wa = anchor;
				link_wd = node_q;
			end
			S_WALK: begin
				rd_addr = walk_hit ? cur_q : walk_next;
			end
			S_ERA_LK: begin
				rd_addr = link_rd;
				link_we = (cur_q != '0);
				link_wa = cur_q;
				link_wd = link_rd;
			end
			S_ERA_REL: begin
				link_we = 1'b1;
				link_wa = node_q;
				link_wd = free_q;
			end
			S_NXT_LK: begin
				rd_addr = link_rd;
			end
			default: begin
				rd_addr = '0;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			op_q        <= REQ_CLEAR;
			elem_q      <= '0;
			status_q    <= ST_DONE;
			sent_q      <= '0;
			cur_q       <= '0;
			tail_q      <= '0;
			free_q      <= '0;
			succ_q      <= '0;
			node_q      <= '0;
			walk_p_q    <= '0;
			len_q       <= '0;
			pos_q       <= '0;
			fresh_q     <= (IW + 1)'(1);
			sval_q      <= '0;
			from_free_q <= 1'b0;
			walk_mem_q  <= 1'b0;
		end else begin
			case (state_q)
				S_IDLE: begin
					if (start) begin
						op_q       <= req.req_type;
						elem_q     <= req.elem_in[VW-1:0];
						status_q   <= ST_DONE;
						walk_p_q   <= '0;
						walk_mem_q <= 1'b0;
						state_q    <= S_DONE;
						case (req.req_type)
							REQ_INSERT, REQ_APPEND: begin
								if (free_q != '0) begin
									node_q      <= free_q;
									from_free_q <= 1'b1;
									state_q     <= S_LINK1;
								end else if (fresh_q != FRESH_END) begin
									node_q      <= fresh_q[IW-1:0];
									fresh_q     <= fresh_q + (IW + 1)'(1);
									from_free_q <= 1'b0;
									state_q     <= S_LINK1;
								end else begin
									status_q <= ST_FULL;
								end
							end
							REQ_ERASE: begin
								if (len_q == '0) begin
									status_q <= ST_EMPTY;
								end else if (cur_q == tail_q) begin
									state_q <= S_WALK;
								end else begin
									node_q  <= succ_q;
									state_q <= S_ERA_LK;
								end
							end
							REQ_NEXT: begin
								if (succ_q != '0) begin
									cur_q   <= succ_q;
									pos_q   <= pos_q + IW'(1);
									state_q <= S_NXT_LK;
								end
							end
							REQ_PREV: begin
								if (cur_q != '0) begin
									state_q <= S_WALK;
								end
							end
							REQ_CLEAR: begin
								sent_q  <= '0;
								cur_q   <= '0;
								tail_q  <= '0;
								succ_q  <= '0;
								len_q   <= '0;
								pos_q   <= '0;
								free_q  <= '0;
								fresh_q <= (IW + 1)'(1);
							end
							default: begin
								state_q <= S_DONE;
							end
						endcase
					end
				end
				S_LINK1: begin
					if (from_free_q) begin
						free_q <= link_rd;
					end
					state_q <= S_LINK2;
				end
				S_LINK2: begin
					if (anchor == '0) begin
						sent_q <= node_q;
					end
					if (op_q == REQ_INSERT) begin
						if (cur_q == tail_q) begin
							tail_q <= node_q;
						end
						succ_q <= node_q;
						sval_q <= elem_q;
					end else begin
						tail_q <= node_q;
						if (cur_q == tail_q) begin
							succ_q <= node_q;
							sval_q <= elem_q;
						end
					end
					len_q   <= len_q + IW'(1);
					state_q <= S_DONE;
				end
				S_WALK: begin
					// one hop per cycle until the predecessor of the cursor shows up
					if (walk_hit) begin
						succ_q  <= cur_q;
						node_q  <= cur_q;
						cur_q   <= walk_p_q;
						pos_q   <= pos_q - IW'(1);
						state_q <= (op_q == REQ_ERASE) ? S_ERA_LK : S_VAL;
					end else begin
						walk_p_q   <= walk_next;
						walk_mem_q <= 1'b1;
					end
				end
				S_ERA_LK: begin
					if (cur_q == '0) begin
						sent_q <= link_rd;
					end
					if (tail_q == node_q) begin
						tail_q <= cur_q;
					end
					succ_q  <= link_rd;
					len_q   <= len_q - IW'(1);
					state_q <= S_ERA_REL;
				end
				S_ERA_REL: begin
					free_q  <= node_q;
					sval_q  <= val_rd;
					state_q <= S_DONE;
				end
				S_NXT_LK: begin
					succ_q  <= link_rd;
					state_q <= S_VAL;
				end
				S_VAL: begin
					sval_q  <= val_rd;
					state_q <= S_DONE;
				end
				S_DONE: begin
					if (res_take) begin
						state_q <= S_IDLE;
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end
endmodule

// ----- hw/rtl/cursor_list_engine_unit.sv -----
// ----------------------------------------------------------------------------
// cursor_list_engine_unit
// Bounded singly linked list with a cursor, kept in a node store with a
// free list; one result item per request item.
// ----------------------------------------------------------------------------
// Usage:
//   req (sink) carries one request item: req_type and elem_in. rsp (source)
//   carries one result item per request: status, length, position,
//   has_current and current_value, all taken after the request is applied.
//   The engine works on one item at a time; req.ready is high only while
//   the sequencer is idle.
//   Clear, full, erase on empty, next at end and prev at head go straight
//   to the result. Insert, append, next and erase with the cursor before
//   the tail step through node store reads and writes. Prev, and erase
//   with the cursor at the tail, first walk back from the head, one link
//   read per cycle, so they take longer the further the cursor is from
//   the head. The next request item is accepted once the sequencer is
//   idle again. The result is held in an output register, so the next
//   request is taken while a result still waits; a second result waits in
//   the sequencer until the register frees up.
//   Reset empties the list, puts the cursor at the head and clears rsp.valid.
//   The node store itself needs no clearing: only list members are read.
// ----------------------------------------------------------------------------
module cursor_list_engine_unit import cle_pkg::*; #(
	parameter int NODES     = 256,
	parameter int ELEM_BITS = 32
) (
	input  logic                clk,
	input  logic                arst_n,
	cle_stream_if.sink          req,
	cle_stream_if.source        rsp
);
	localparam int IW = $clog2(NODES);
	localparam int VW = (ELEM_BITS < 32) ? ELEM_BITS : 32;

	logic          seq_idle;
	logic          seq_res_valid;
	logic          seq_res_take;
	rsp_t          seq_res;
	logic          start;

	logic [IW-1:0] rd_addr;
	logic [IW-1:0] link_rd;
	logic [VW-1:0] val_rd;
	logic          link_we;
	logic [IW-1:0] link_wa;
	logic [IW-1:0] link_wd;
	logic          val_we;
	logic [IW-1:0] val_wa;
	logic [VW-1:0] val_wd;

	logic          rsp_valid_q;
	rsp_t          rsp_q;

	// accept only while the sequencer has nothing in flight
	assign req.ready = seq_idle;
	assign start     = req.valid && seq_idle;

	// hand a finished result over when the output register is empty or draining
	assign seq_res_take = !rsp_valid_q || rsp.ready;

	assign rsp.valid = rsp_valid_q;
	assign rsp.data  = rsp_q;

	cle_seq #(
		.NODES     (NODES),
		.ELEM_BITS (ELEM_BITS)
	) u_seq (
		.clk       (clk),
		.arst_n    (arst_n),
		.start     (start),
		.req       (req.data),
		.idle      (seq_idle),
		.res_valid (seq_res_valid),
		.res_take  (seq_res_take),
		.res       (seq_res),
		.rd_addr   (rd_addr),
		.link_rd   (link_rd),
		.val_rd    (val_rd),
		.link_we   (link_we),
		.link_wa   (link_wa),
		.link_wd   (link_wd),
		.val_we    (val_we),
		.val_wa    (val_wa),
		.val_wd    (val_wd)
	);

	cle_node_mem #(
		.NODES    (NODES),
		.VAL_BITS (VW)
	) u_mem (
		.clk     (clk),
		.rd_addr (rd_addr),
		.link_rd (link_rd),
		.val_rd  (val_rd),
		.link_we (link_we),
		.link_wa (link_wa),
		.link_wd (link_wd),
		.val_we  (val_we),
		.val_wa  (val_wa),
		.val_wd  (val_wd)
	);

	// output register: load a new result, otherwise hold until taken
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rsp_valid_q <= 1'b0;
		end else if (seq_res_valid && seq_res_take) begin
			rsp_valid_q <= 1'b1;
		end else if (rsp.ready) begin
			rsp_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (seq_res_valid && seq_res_take) begin
			rsp_q <= seq_res;
		end
	end

	// one item at a time: ready drops right after an accept
	a_one_in_flight: assert property (@(posedge clk) disable iff (!arst_n)
		req.valid && req.ready |=> !req.ready)
		else $error("request accepted while the sequencer was busy");

	// a full store always holds NODES-1 elements
	a_full_length: assert property (@(posedge clk) disable iff (!arst_n)
		rsp.valid && rsp.data.status == ST_FULL |-> rsp.data.length == 8'(NODES - 1))
		else $error("store full reported with a wrong length");

	// erase on empty leaves the cursor at the head with nothing after it
	a_empty_view: assert property (@(posedge clk) disable iff (!arst_n)
		rsp.valid && rsp.data.status == ST_EMPTY |->
			rsp.data.length == 8'd0 && rsp.data.position == 8'd0 && !rsp.data.has_current)
		else $error("empty list reported with a non-empty view");
endmodule

// ----- dv/tb_cursor_list_engine_unit.sv -----
// ----------------------------------------------------------------------------
// tb_cursor_list_engine_unit
// Self-checking bench for the cursor list engine. A shadow copy of the list
// (node store, free list, cursor and tail) predicts every result item. A
// short table of requests, some with hand-written answers, comes first. Random
// traffic follows, including a fill of the whole store, and is checked
// against the shadow. Both channels idle at random; two receiver hold-offs
// back up the engine, and sender pauses drain it.
// ----------------------------------------------------------------------------
module tb_cursor_list_engine_unit;
	timeunit 1ns;
	timeprecision 1ps;

	import cle_pkg::*;

	// Request codes with no operation behind them; the engine must ignore both.
	localparam logic [2:0] REQ_RSVD_A = 3'd6;
	localparam logic [2:0] REQ_RSVD_B = 3'd7;

	localparam int ITEM_TARGET    = 1950;
	localparam int HOLDOFF_CYCLES = 200;
	// Longest single request is a walk back over a full list.
	localparam int SETTLE_CYCLES  = 300;
	localparam int REPORT_LIMIT   = 10;

	typedef struct {
		logic [2:0]  kind;
		logic [31:0] elem;
		bit          pinned;
		rsp_t        view;
	} row_t;

	logic clk = 1'b0;
	logic arst_n;

	cle_stream_if #(.T(req_t)) req_if ();
	cle_stream_if #(.T(rsp_t)) rsp_if ();

	cursor_list_engine_unit dut (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (req_if),
		.rsp    (rsp_if)
	);

	always begin
		#6 clk = 1'b1;
		#6 clk = 1'b0;
	end

	// ------------------------------------------------------------------------
	// Shadow list: same node store layout as the engine. Node 0 is the
	// sentinel whose link lives in its own register.
	// ------------------------------------------------------------------------
	logic [31:0] shadow_val  [256];
	logic [7:0]  shadow_link [256];
	logic [7:0]  shadow_head_link;
	logic [7:0]  shadow_cursor;
	logic [7:0]  shadow_tail;
	logic [7:0]  shadow_len;
	logic [7:0]  shadow_pos;
	logic [7:0]  shadow_free;
	logic [8:0]  shadow_fresh;

	// Views still owed by the engine, oldest first.
	rsp_t awaited_views[$];
	row_t script[$];

	int  fault_count    = 0;
	int  useful_items   = 0;
	bit  steady         = 1'b0;
	int  holdoff_asks   = 0;
	int  holdoff_served = 0;
	int  stall_left     = 0;

	function automatic void reset_shadow();
		shadow_head_link = 8'd0;
		shadow_cursor    = 8'd0;
		shadow_tail      = 8'd0;
		shadow_len       = 8'd0;
		shadow_pos       = 8'd0;
		shadow_free      = 8'd0;
		shadow_fresh     = 9'd1;
	endfunction

	function automatic logic [7:0] link_at(input logic [7:0] n);
		return (n == 8'd0) ? shadow_head_link : shadow_link[n];
	endfunction

	function automatic void set_link_at(input logic [7:0] n, input logic [7:0] to);
		if (n == 8'd0) begin
			shadow_head_link = to;
		end else begin
			shadow_link[n] = to;
		end
	endfunction

	// Reuse released nodes first, then hand out fresh ones; 0 means full.
	function automatic logic [7:0] grab_node();
		logic [7:0] n;
		n = 8'd0;
		if (shadow_free != 8'd0) begin
			n = shadow_free;
			shadow_free = shadow_link[n];
		end else if (shadow_fresh < 9'd256) begin
			n = shadow_fresh[7:0];
			shadow_fresh = shadow_fresh + 9'd1;
		end
		return n;
	endfunction

	// Walk from the sentinel to the node whose link is the cursor.
	function automatic void step_cursor_back();
		logic [7:0] n;
		n = 8'd0;
		if (shadow_cursor != 8'd0) begin
			for (int i = 0; i < 256; i++) begin
				if (link_at(n) == shadow_cursor)
					break;
				n = link_at(n);
			end
			shadow_cursor = n;
			shadow_pos = shadow_pos - 8'd1;
		end
	endfunction

	// Apply one request to the shadow and return the view the engine reports.
	function automatic rsp_t apply_to_shadow(input req_t r);
		logic [7:0] n;
		rsp_t       v;
		v = '0;
		v.status = ST_DONE;
		case (r.req_type)
			REQ_INSERT, REQ_APPEND: begin
				n = grab_node();
				if (n == 8'd0) begin
					v.status = ST_FULL;
				end else begin
					shadow_val[n] = r.elem_in;
					if (r.req_type == REQ_INSERT) begin
						shadow_link[n] = link_at(shadow_cursor);
						set_link_at(shadow_cursor, n);
						if (shadow_cursor == shadow_tail)
							shadow_tail = n;
					end else begin
						shadow_link[n] = 8'd0;
						set_link_at(shadow_tail, n);
						shadow_tail = n;
					end
					shadow_len = shadow_len + 8'd1;
				end
			end
			REQ_ERASE: begin
				if (shadow_len == 8'd0) begin
					v.status = ST_EMPTY;
				end else begin
					// At the tail nothing follows the cursor: back up one node first.
					if (shadow_cursor == shadow_tail)
						step_cursor_back();
					n = link_at(shadow_cursor);
					set_link_at(shadow_cursor, link_at(n));
					if (shadow_tail == n)
						shadow_tail = shadow_cursor;
					shadow_link[n] = shadow_free;
					shadow_free = n;
					shadow_len = shadow_len - 8'd1;
				end
			end
			REQ_NEXT: begin
				n = link_at(shadow_cursor);
				if (n != 8'd0) begin
					shadow_cursor = n;
					shadow_pos = shadow_pos + 8'd1;
				end
			end
			REQ_PREV: step_cursor_back();
			REQ_CLEAR: reset_shadow();
			default: ;
		endcase
		n = link_at(shadow_cursor);
		v.length        = shadow_len;
		v.position      = shadow_pos;
		v.has_current   = (n != 8'd0);
		v.current_value = (n != 8'd0) ? shadow_val[n] : 32'd0;
		return v;
	endfunction

	function automatic logic [31:0] draw_element();
		case ($urandom_range(15))
			0: return 32'h7fff_ffff;
			1: return 32'h8000_0000;
			2: return 32'h0000_0000;
			3: return 32'hffff_ffff;
			default: return $urandom;
		endcase
	endfunction

	function automatic string describe(input rsp_t v);
		return $sformatf("status %0d length %0d position %0d has_current %0b value %h",
			v.status, v.length, v.position, v.has_current, v.current_value);
	endfunction

	// Count every fault; print only the first few.
	function automatic void log_fault(input string msg);
		if (fault_count < REPORT_LIMIT)
			$display("[%0t] mismatch: %s", $realtime, msg);
		fault_count++;
	endfunction

	// ------------------------------------------------------------------------
	// Sender side
	// ------------------------------------------------------------------------

	// Offer one request item, wait for the handshake, then predict its view.
	// A pinned row pushes the hand-written view instead of the shadow's.
	task automatic offer(input logic [2:0] kind, input logic [31:0] elem,
			input bit pinned, input rsp_t pinned_view);
		req_t item;
		rsp_t view;
		item.req_type = kind;
		item.elem_in  = elem;
		// Idle at random between items unless in a steady stretch.
		while (!steady && $urandom_range(99) < 38) begin
			req_if.valid <= 1'b0;
			@(posedge clk);
		end
		req_if.valid <= 1'b1;
		req_if.data  <= item;
		do @(posedge clk); while (!req_if.ready);
		view = apply_to_shadow(item);
		awaited_views.push_back(pinned ? pinned_view : view);
		if (!(kind inside {REQ_RSVD_A, REQ_RSVD_B}))
			useful_items++;
	endtask

	task automatic add_row(input logic [2:0] kind, input logic [31:0] elem,
			input bit pinned, input logic [1:0] status, input logic [7:0] len,
			input logic [7:0] pos, input logic has_cur, input logic [31:0] val);
		row_t r;
		r.kind   = kind;
		r.elem   = elem;
		r.pinned = pinned;
		r.view.status        = status;
		r.view.length        = len;
		r.view.position      = pos;
		r.view.has_current   = has_cur;
		r.view.current_value = val;
		script.push_back(r);
	endtask

	// Drop valid and hold until every awaited view has come back.
	task automatic hold_until_drained();
		req_if.valid <= 1'b0;
		do @(posedge clk); while (awaited_views.size() != 0);
	endtask

	// Random mix weighted so lists stay short and walks back stay cheap.
	task automatic run_mixed(input int count);
		logic [2:0] kind;
		int         roll;
		repeat (count) begin
			roll = $urandom_range(99);
			if (roll < 24)
				kind = REQ_INSERT;
			else if (roll < 46)
				kind = REQ_APPEND;
			else if (roll < 66)
				kind = REQ_ERASE;
			else if (roll < 80)
				kind = REQ_NEXT;
			else if (roll < 91)
				kind = REQ_PREV;
			else if (roll < 96)
				kind = REQ_CLEAR;
			else if (roll < 98)
				kind = REQ_RSVD_A;
			else
				kind = REQ_RSVD_B;
			offer(kind, draw_element(), 1'b0, '0);
		end
	endtask

	// Fill the whole store, push past full, walk to the far end, punch holes
	// and refill them from the free list until full again.
	task automatic fill_store();
		offer(REQ_CLEAR, draw_element(), 1'b0, '0);
		while (shadow_len != 8'd255) begin
			if ($urandom_range(9) == 0)
				offer(REQ_NEXT, draw_element(), 1'b0, '0);
			else
				offer($urandom_range(1) ? REQ_INSERT : REQ_APPEND, draw_element(), 1'b0, '0);
		end
		offer(REQ_INSERT, draw_element(), 1'b0, '0);
		offer(REQ_APPEND, draw_element(), 1'b0, '0);
		while (link_at(shadow_cursor) != 8'd0)
			offer(REQ_NEXT, draw_element(), 1'b0, '0);
		offer(REQ_NEXT, draw_element(), 1'b0, '0);
		offer(REQ_ERASE, draw_element(), 1'b0, '0);
		repeat (12) begin
			offer($urandom_range(1) ? REQ_PREV : REQ_NEXT, draw_element(), 1'b0, '0);
			offer(REQ_ERASE, draw_element(), 1'b0, '0);
		end
		while (shadow_len != 8'd255)
			offer($urandom_range(1) ? REQ_INSERT : REQ_APPEND, draw_element(), 1'b0, '0);
		offer(REQ_APPEND, draw_element(), 1'b0, '0);
		offer(REQ_INSERT, draw_element(), 1'b0, '0);
	endtask

	initial begin
		arst_n       = 1'b0;
		req_if.valid = 1'b0;
		req_if.data  = '0;
		rsp_if.ready = 1'b0;
		reset_shadow();

		// Directed rows. Rows with a typed answer start from reset and need no
		// arithmetic; the rest lean on the shadow.
		add_row(REQ_NEXT,   32'h0,         1'b1, ST_DONE,  8'd0, 8'd0, 1'b0, 32'h0);
		add_row(REQ_PREV,   32'h0,         1'b1, ST_DONE,  8'd0, 8'd0, 1'b0, 32'h0);
		add_row(REQ_ERASE,  32'h0,         1'b1, ST_EMPTY, 8'd0, 8'd0, 1'b0, 32'h0);
		add_row(REQ_INSERT, 32'h7fff_ffff, 1'b1, ST_DONE,  8'd1, 8'd0, 1'b1, 32'h7fff_ffff);
		add_row(REQ_APPEND, 32'h8000_0000, 1'b1, ST_DONE,  8'd2, 8'd0, 1'b1, 32'h7fff_ffff);
		add_row(REQ_NEXT,   32'h0,         1'b1, ST_DONE,  8'd2, 8'd1, 1'b1, 32'h8000_0000);
		add_row(REQ_NEXT,   32'h0,         1'b1, ST_DONE,  8'd2, 8'd2, 1'b0, 32'h0);
		// Next at the end of the list: cursor stays.
		add_row(REQ_NEXT,   32'h0,         1'b1, ST_DONE,  8'd2, 8'd2, 1'b0, 32'h0);
		add_row(REQ_INSERT, 32'h0,         1'b1, ST_DONE,  8'd3, 8'd2, 1'b1, 32'h0);
		add_row(REQ_APPEND, 32'hffff_ffff, 1'b0, ST_DONE,  8'd0, 8'd0, 1'b0, 32'h0);
		add_row(REQ_NEXT,   32'h0,         1'b0, ST_DONE,  8'd0, 8'd0, 1'b0, 32'h0);
		add_row(REQ_NEXT,   32'h0,         1'b0, ST_DONE,  8'd0, 8'd0, 1'b0, 32'h0);
		// Erase with the cursor on the tail: the cursor backs up first.
		add_row(REQ_ERASE,  32'h0,         1'b0, ST_DONE,  8'd0, 8'd0, 1'b0, 32'h0);
		add_row(REQ_PREV,   32'h0,         1'b0, ST_DONE,  8'd0, 8'd0, 1'b0, 32'h0);
		add_row(REQ_ERASE,  32'h0,         1'b0, ST_DONE,  8'd0, 8'd0, 1'b0, 32'h0);
		// Takes a node back off the free list.
		add_row(REQ_INSERT, 32'h5a5a_a5a5, 1'b0, ST_DONE,  8'd0, 8'd0, 1'b0, 32'h0);
		add_row(REQ_RSVD_A, 32'h1234_5678, 1'b0, ST_DONE,  8'd0, 8'd0, 1'b0, 32'h0);
		add_row(REQ_RSVD_B, 32'hedcb_a987, 1'b0, ST_DONE,  8'd0, 8'd0, 1'b0, 32'h0);
		add_row(REQ_CLEAR,  32'h0,         1'b1, ST_DONE,  8'd0, 8'd0, 1'b0, 32'h0);
		add_row(REQ_ERASE,  32'h0,         1'b1, ST_EMPTY, 8'd0, 8'd0, 1'b0, 32'h0);
		add_row(REQ_APPEND, 32'h0000_0001, 1'b1, ST_DONE,  8'd1, 8'd0, 1'b1, 32'h1);
		// Prev at the sentinel with a non-empty list: cursor stays.
		add_row(REQ_PREV,   32'h0,         1'b1, ST_DONE,  8'd1, 8'd0, 1'b1, 32'h1);
		add_row(REQ_CLEAR,  32'h0,         1'b1, ST_DONE,  8'd0, 8'd0, 1'b0, 32'h0);

		repeat (5) @(posedge clk);
		arst_n <= 1'b1;

		foreach (script[i])
			offer(script[i].kind, script[i].elem, script[i].pinned, script[i].view);

		run_mixed(300);

		// Hold off the receiver while requests keep coming, so the result
		// register and the sequencer fill and the request side stalls.
		holdoff_asks <= holdoff_asks + 1;
		run_mixed(150);

		// Let the engine run dry before the big fill.
		hold_until_drained();
		fill_store();

		// A stretch with no idling on either side.
		steady <= 1'b1;
		run_mixed(200);
		steady <= 1'b0;

		hold_until_drained();
		holdoff_asks <= holdoff_asks + 1;
		while (useful_items < ITEM_TARGET)
			run_mixed(ITEM_TARGET - useful_items);

		hold_until_drained();
		repeat (SETTLE_CYCLES) @(posedge clk);
		if (fault_count == 0) begin
			$display("PASSED: all results match");
		end else begin
			$display("FAILED: results differ");
		end
		$finish;
	end

	// ------------------------------------------------------------------------
	// Receiver side: random ready, steady stretches, and long hold-offs on
	// request from the stimulus.
	// ------------------------------------------------------------------------
	always @(posedge clk) begin
		if (!arst_n) begin
			rsp_if.ready <= 1'b0;
			stall_left   <= 0;
		end else if (holdoff_asks != holdoff_served) begin
			holdoff_served <= holdoff_asks;
			stall_left     <= HOLDOFF_CYCLES;
			rsp_if.ready   <= 1'b0;
		end else if (stall_left != 0) begin
			stall_left   <= stall_left - 1;
			rsp_if.ready <= 1'b0;
		end else begin
			rsp_if.ready <= steady || ($urandom_range(99) >= 38);
		end
	end

	// Compare each accepted result with the oldest awaited view.
	always @(posedge clk) begin : check_results
		rsp_t want;
		rsp_t got;
		if (arst_n && rsp_if.valid && rsp_if.ready) begin
			got = rsp_if.data;
			if (awaited_views.size() == 0) begin
				log_fault({"result with nothing awaited: ", describe(got)});
			end else begin
				want = awaited_views.pop_front();
				if (got.status !== want.status || got.length !== want.length ||
						got.position !== want.position ||
						got.has_current !== want.has_current ||
						got.current_value !== want.current_value)
					log_fault({"expected ", describe(want), ", got ", describe(got)});
			end
		end
	end

	// Hard stop in case the engine hangs.
	initial begin
		#40_000_000;
		$display("FAILED: results differ");
		$finish;
	end

endmodule
